// ===== src/indexed_list_store_unit_macros.svh =====
// Assertion macros for the indexed list store unit.
`ifndef INDEXED_LIST_STORE_UNIT_MACROS_SVH
`define INDEXED_LIST_STORE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, idle in reset.
`define ILSU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ilsu check failed");

// Next-cycle implication, sampled on clk, idle in reset.
`define ILSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ilsu check failed");

`endif

// ===== src/ilsu_pkg.sv =====
// Shared types and constants of the indexed list store unit.
`default_nettype none

package ilsu_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int ELEM_WIDTH_DEF = 32;

    // Widest index / count the cell command can carry (CAPACITY up to 1024).
    localparam int IDX_MAX_W = 10;
    localparam int CNT_MAX_W = 11;

    typedef enum logic [2:0] {
        REQ_PUSH   = 3'd0,
        REQ_POP    = 3'd1,
        REQ_SET    = 3'd2,
        REQ_GET    = 3'd3,
        REQ_INSERT = 3'd4,
        REQ_REMOVE = 3'd5,
        REQ_FIND   = 3'd6,
        REQ_TOP    = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_NOP    = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_REMOVE = 2'd3
    } cell_op_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        cell_op_t             op;
        logic [IDX_MAX_W-1:0] pos;  // write / insert / remove index
        logic [IDX_MAX_W-1:0] top;  // last index touched by a shift
        logic [CNT_MAX_W-1:0] cnt;  // current fill, for match gating
    } cell_cmd_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] read_value;
        logic [3:0]  found_position;
        logic [4:0]  entry_count;
    } rsp_t;

endpackage

`default_nettype wire

// ===== src/ilsu_cell.sv =====
// One storage cell of the list chain: holds an entry, shifts with its neighbors.
`default_nettype none

module ilsu_cell #(
    parameter int CAPACITY   = ilsu_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = ilsu_pkg::ELEM_WIDTH_DEF,
    parameter int IDX        = 0
) (
    input  wire logic                  clk,
    input  wire ilsu_pkg::cell_cmd_t   cmd,
    input  wire logic [ELEM_WIDTH-1:0] val,
    input  wire logic [ELEM_WIDTH-1:0] left_data,
    input  wire logic [ELEM_WIDTH-1:0] right_data,
    output logic      [ELEM_WIDTH-1:0] data,
    output logic                       hit
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);
    localparam logic [CW-1:0] MY_CNT = CW'(IDX);

    logic [ELEM_WIDTH-1:0] data_reg;
    logic [ELEM_WIDTH-1:0] data_next;
    logic [IW-1:0]         pos;
    logic [IW-1:0]         top;

    assign pos = cmd.pos[IW-1:0];
    assign top = cmd.top[IW-1:0];

    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            ilsu_pkg::CELL_WRITE:
            begin
                if (MY_IDX == pos)
                    data_next = val;
            end
            ilsu_pkg::CELL_INSERT:
            begin
                if (MY_IDX == pos)
                    data_next = val;
                else if (MY_IDX > pos && MY_IDX <= top)
                    data_next = left_data;
            end
            ilsu_pkg::CELL_REMOVE:
            begin
                if (MY_IDX == top)
                    data_next = '0;
                else if (MY_IDX >= pos && MY_IDX < top)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    // only occupied cells may match
    assign hit  = (MY_CNT < cmd.cnt[CW-1:0]) && (data_reg == val);

endmodule

`default_nettype wire

// ===== src/indexed_list_store_unit.sv =====
// Top level of the indexed list store unit: control, cell chain and response register.
//
// Ordered list of up to CAPACITY words held in a chain of cells. Each request
// (push, pop, set, get, insert, remove, find, top) is taken with req_valid high
// and req_stall low, and yields exactly one response on the rsp channel. A
// request is registered in the transfer cycle and executed in the next one:
// set/get/push/pop/insert/remove/top finish there and load the response
// register, or wait in a hold state while it is still occupied; a new request
// is taken once the block is idle again. Insert and remove move the cells from
// the index to the end of the list by one place in the execute cycle. Find
// compares all cells at once, latches the hit vector, then scans it one index
// per cycle for the lowest match, up to the last entry. req_stall is high while a
// request is in flight or while a finished response waits for the response register.
// Reset clears count and control state only; cell contents are never read beyond it.
`default_nettype none

module indexed_list_store_unit #(
    parameter int CAPACITY   = ilsu_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = ilsu_pkg::ELEM_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [2:0]  req_type,
    input  wire logic [3:0]  position,
    input  wire logic [31:0] item_value,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [1:0]       status,
    output logic [31:0]      read_value,
    output logic [3:0]       found_position,
    output logic [4:0]       entry_count
);

    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int IMW = ilsu_pkg::IDX_MAX_W;
    localparam int CMW = ilsu_pkg::CNT_MAX_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_HOLD
    } state_t;

    state_t                state_reg;
    ilsu_pkg::req_t        op_reg;
    logic [3:0]            pos_reg;
    logic [ELEM_WIDTH-1:0] val_reg;
    logic [CW-1:0]         used_count_reg;
    logic [CAPACITY-1:0]   hit_reg;
    logic [IW-1:0]         scan_idx_reg;
    ilsu_pkg::rsp_t        pend_reg;
    ilsu_pkg::rsp_t        rsp_reg;
    logic                  rsp_valid_reg;

    logic [63:0]           item_ext;
    logic [ELEM_WIDTH-1:0] data   [CAPACITY];
    logic [CAPACITY-1:0]   hits;
    ilsu_pkg::cell_cmd_t   cmd;
    logic [CW-1:0]         cnt;
    logic [CW-1:0]         cnt_next;
    logic [CW-1:0]         cnt_dec;
    logic                  idx_ok;
    logic                  full;
    logic                  empty;
    logic [IW-1:0]         rd_idx;
    logic [63:0]           rd_ext;
    ilsu_pkg::rsp_t        res;
    logic                  res_done;
    logic                  go_scan;
    logic                  out_free;
    logic                  rsp_load;

    // item_value is cut or widened to the element width
    assign item_ext = 64'(item_value);

    // ------------------------------------------------------------------
    // cell chain: cell i sees cell i-1 on its left and cell i+1 on its right
    // ------------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ELEM_WIDTH-1:0] left_d;
        logic [ELEM_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_left
            assign left_d = data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_right
            assign right_d = data[i+1];
        end

        ilsu_cell #(
            .CAPACITY   (CAPACITY),
            .ELEM_WIDTH (ELEM_WIDTH),
            .IDX        (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .val        (val_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (data[i]),
            .hit        (hits[i])
        );
    end

    // ------------------------------------------------------------------
    // request decode, executed in S_EXEC from the registered request
    // ------------------------------------------------------------------
    assign cnt     = used_count_reg;
    assign cnt_dec = cnt - 1'b1;
    assign idx_ok  = (32'(pos_reg) < 32'(cnt));
    assign full    = (cnt == FULL_CNT);
    assign empty   = (cnt == '0);
    assign rd_idx  = (op_reg == ilsu_pkg::REQ_TOP) ? IW'(cnt_dec) : IW'(pos_reg);
    assign rd_ext  = 64'(data[rd_idx]);

    always_comb
    begin
        cmd.op   = ilsu_pkg::CELL_NOP;
        cmd.pos  = IMW'(IW'(pos_reg));
        cmd.top  = IMW'(IW'(cnt));
        cmd.cnt  = CMW'(cnt);
        cnt_next = cnt;
        res_done = 1'b0;
        go_scan  = 1'b0;
        res.status         = ilsu_pkg::ST_OK;
        res.read_value     = '0;
        res.found_position = '0;
        res.entry_count    = '0;

        if (state_reg == S_EXEC)
        begin
            res_done = 1'b1;
            case (op_reg)
                ilsu_pkg::REQ_PUSH:
                begin
                    if (full)
                        res.status = ilsu_pkg::ST_FULL;
                    else
                    begin
                        cmd.op   = ilsu_pkg::CELL_WRITE;
                        cmd.pos  = IMW'(IW'(cnt));
                        cnt_next = cnt + 1'b1;
                    end
                end
                ilsu_pkg::REQ_POP:
                begin
                    if (empty)
                        res.status = ilsu_pkg::ST_RANGE;
                    else
                    begin
                        cmd.op   = ilsu_pkg::CELL_REMOVE;
                        cmd.pos  = IMW'(IW'(cnt_dec));
                        cmd.top  = IMW'(IW'(cnt_dec));
                        cnt_next = cnt_dec;
                    end
                end
                ilsu_pkg::REQ_SET:
                begin
                    if (!idx_ok)
                        res.status = ilsu_pkg::ST_RANGE;
                    else
                        cmd.op = ilsu_pkg::CELL_WRITE;
                end
                ilsu_pkg::REQ_GET:
                begin
                    if (!idx_ok)
                        res.status = ilsu_pkg::ST_RANGE;
                    else
                        res.read_value = rd_ext[31:0];
                end
                ilsu_pkg::REQ_INSERT:
                begin
                    if (!idx_ok)
                        res.status = ilsu_pkg::ST_RANGE;
                    else if (full)
                        res.status = ilsu_pkg::ST_FULL;
                    else
                    begin
                        cmd.op   = ilsu_pkg::CELL_INSERT;
                        cnt_next = cnt + 1'b1;
                    end
                end
                ilsu_pkg::REQ_REMOVE:
                begin
                    if (!idx_ok)
                        res.status = ilsu_pkg::ST_RANGE;
                    else
                    begin
                        cmd.op   = ilsu_pkg::CELL_REMOVE;
                        cmd.top  = IMW'(IW'(cnt_dec));
                        cnt_next = cnt_dec;
                    end
                end
                ilsu_pkg::REQ_FIND:
                begin
                    if (empty)
                        res.status = ilsu_pkg::ST_MISS;
                    else
                    begin
                        res_done = 1'b0;
                        go_scan  = 1'b1;
                    end
                end
                default:
                begin
                    // top
                    if (empty)
                        res.status = ilsu_pkg::ST_RANGE;
                    else
                        res.read_value = rd_ext[31:0];
                end
            endcase
        end
        else if (state_reg == S_SCAN)
        begin
            // lowest set bit of the latched hit vector, one index per cycle
            if (hit_reg[scan_idx_reg])
            begin
                res_done           = 1'b1;
                res.found_position = 4'(scan_idx_reg);
            end
            else if (CW'(scan_idx_reg) == cnt_dec)
            begin
                res_done   = 1'b1;
                res.status = ilsu_pkg::ST_MISS;
            end
        end

        res.entry_count = 5'(cnt_next);
    end

    assign out_free = !rsp_valid_reg || !rsp_stall;
    // a finished or parked response moves into the output register
    assign rsp_load = out_free && (res_done || (state_reg == S_HOLD));

    // ------------------------------------------------------------------
    // sequencer, request and response registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_count_reg <= '0;
            rsp_valid_reg  <= 1'b0;
            op_reg         <= ilsu_pkg::REQ_PUSH;
            pos_reg        <= '0;
            val_reg        <= '0;
            hit_reg        <= '0;
            scan_idx_reg   <= '0;
            pend_reg       <= '0;
            rsp_reg        <= '0;
        end
        else
        begin
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        op_reg    <= ilsu_pkg::req_t'(req_type);
                        pos_reg   <= position;
                        val_reg   <= item_ext[ELEM_WIDTH-1:0];
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC, S_SCAN:
                begin
                    used_count_reg <= cnt_next;
                    if (go_scan)
                    begin
                        hit_reg      <= hits;
                        scan_idx_reg <= '0;
                        state_reg    <= S_SCAN;
                    end
                    else if (res_done)
                    begin
                        if (out_free)
                        begin
                            rsp_reg   <= res;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            pend_reg  <= res;
                            state_reg <= S_HOLD;
                        end
                    end
                    else
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                S_HOLD:
                begin
                    if (out_free)
                    begin
                        rsp_reg   <= pend_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_stall      = (state_reg != S_IDLE);
    assign rsp_valid      = rsp_valid_reg;
    assign status         = rsp_reg.status;
    assign read_value     = rsp_reg.read_value;
    assign found_position = rsp_reg.found_position;
    assign entry_count    = rsp_reg.entry_count;

endmodule

`default_nettype wire

// ===== src/ilsu_checker.sv =====
// Port-level checks of the indexed list store unit, bound to the top level.
`default_nettype none

`include "indexed_list_store_unit_macros.svh"

module ilsu_checker #(
    parameter int CAPACITY = ilsu_pkg::CAPACITY_DEF
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_stall,
    input wire logic        rsp_valid,
    input wire logic        rsp_stall,
    input wire logic [1:0]  status,
    input wire logic [31:0] read_value,
    input wire logic [3:0]  found_position,
    input wire logic [4:0]  entry_count
);

    localparam logic [4:0] CAP_CNT  = 5'(CAPACITY);
    localparam bit         CNT_FITS = (CAPACITY < 32);

    logic [42:0] rsp_bits;
    logic        rsp_full;
    logic        rsp_failed;
    logic        rsp_empty_data;

    assign rsp_bits       = {status, read_value, found_position, entry_count};
    assign rsp_full       = rsp_valid && (status == ilsu_pkg::ST_FULL);
    assign rsp_failed     = rsp_valid && (status != ilsu_pkg::ST_OK);
    assign rsp_empty_data = (read_value == '0) && (found_position == '0);

    // a stalled response holds
    `ILSU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_bits))

    // a request transfer keeps the block busy for the next cycle
    `ILSU_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

    // a refused push or insert means the store is full
    `ILSU_ASSERT_NOW(a_full_count, rsp_full && CNT_FITS, entry_count == CAP_CNT)

    // failed requests read nothing
    `ILSU_ASSERT_NOW(a_fail_zero, rsp_failed, rsp_empty_data)

    // the fill never exceeds the capacity
    `ILSU_ASSERT_NOW(a_count_cap, rsp_valid && CNT_FITS, entry_count <= CAP_CNT)

endmodule

bind indexed_list_store_unit ilsu_checker #(.CAPACITY(CAPACITY)) u_ilsu_checker (.*);

`default_nettype wire
